>>> hdl/itlc_pkg.sv
// itlc_pkg: shared types, codes and helpers for the instruction trace loop collapser
// used by itlc_core, itlc_rec_fifo and instruction_trace_loop_collapser_top
package itlc_pkg;

    localparam logic [1:0] ACT_INSTR = 2'd0;
    localparam logic [1:0] ACT_FLUSH = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] CFG_WIN_LO = 2'd0;
    localparam logic [1:0] CFG_WIN_HI = 2'd1;
    localparam logic [1:0] CFG_REC_EN = 2'd2;

    localparam logic [31:0] SAT32   = 32'hFFFF_FFFF;
    localparam logic [7:0]  STD_MAX = 8'hFF;
    localparam logic [15:0] PC_MAX  = 16'hFFFF;

    localparam int IN_TDATA_W  = 136;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 88;

    typedef struct packed {
        logic [1:0]       action;
        logic [15:0]      instr_pc;
        logic [15:0]      next_pc;
        logic [31:0]      total_cyc;
        logic [31:0]      wait_cyc;
        logic [2:0]       len;
        logic [3:0][7:0]  op;
    } t_item;

    typedef struct packed {
        logic [15:0]      pc;
        logic [2:0]       len;
        logic [3:0][7:0]  op;
        logic [31:0]      wait_cyc;
        logic             last;
    } t_record;

    typedef struct packed {
        logic [1:0] n_rec;
        t_record    rec_a;
        t_record    rec_b;
    } t_emit;

    typedef struct packed {
        logic [15:0] win_lo;
        logic [15:0] win_hi;
        logic        rec_en;
    } t_cfg;

    function automatic logic [2:0] clamp_len(input logic [2:0] len);
        logic [2:0] l;
        l = len;
        if (l == 3'd0) l = 3'd1;
        if (l > 3'd4) l = 3'd4;
        return l;
    endfunction

endpackage

>>> hdl/itlc_core.sv
// itlc_core: collapse state and single-pass record generation for one request
// depends on itlc_pkg
module itlc_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  itlc_pkg::t_item i_item,
    input  itlc_pkg::t_cfg  i_cfg,
    output itlc_pkg::t_emit o_emit
);
    import itlc_pkg::*;

    logic             r_seen;
    logic [31:0]      r_pending;
    logic [15:0]      r_loop_pc;
    logic [2:0]       r_loop_len;
    logic [3:0][7:0]  r_loop_op;

    logic             n_seen;
    logic [31:0]      n_pending;
    logic [15:0]      n_loop_pc;
    logic [2:0]       n_loop_len;
    logic [3:0][7:0]  n_loop_op;

    logic [2:0]       len_c;
    logic [3:0][7:0]  op_pad;
    logic [32:0]      diff;
    logic [7:0]       std_time;
    logic [32:0]      sum1;
    logic [31:0]      part1;
    logic [32:0]      sum2;
    logic [31:0]      part2;
    logic             in_win;
    t_record          loop_rec;
    t_record          cur_rec;

    always_comb begin
        len_c = clamp_len(i_item.len);
        for (int i = 0; i < 4; i++) begin
            op_pad[i] = (3'(i) < len_c) ? i_item.op[i] : 8'd0;
        end
        diff = {1'b0, i_item.total_cyc} - {1'b0, i_item.wait_cyc};
        if (diff[32]) begin
            std_time = 8'd0;
        end else if (diff[31:0] > {24'd0, STD_MAX}) begin
            std_time = STD_MAX;
        end else begin
            std_time = diff[7:0];
        end
        sum1  = {1'b0, r_pending} + {25'd0, std_time};
        part1 = sum1[32] ? SAT32 : sum1[31:0];
        sum2  = {1'b0, part1} + {1'b0, i_item.wait_cyc};
        part2 = sum2[32] ? SAT32 : sum2[31:0];
        in_win = (i_item.instr_pc >= i_cfg.win_lo) && (i_item.instr_pc <= i_cfg.win_hi);

        loop_rec.pc       = r_loop_pc;
        loop_rec.len      = r_loop_len;
        loop_rec.op       = r_loop_op;
        loop_rec.wait_cyc = r_pending;
        loop_rec.last     = 1'b0;

        cur_rec.pc        = i_item.instr_pc;
        cur_rec.len       = len_c;
        cur_rec.op        = op_pad;
        cur_rec.wait_cyc  = i_item.wait_cyc;
        cur_rec.last      = 1'b1;
    end

    always_comb begin
        n_seen     = r_seen;
        n_pending  = r_pending;
        n_loop_pc  = r_loop_pc;
        n_loop_len = r_loop_len;
        n_loop_op  = r_loop_op;
        o_emit.n_rec = 2'd0;
        o_emit.rec_a = loop_rec;
        o_emit.rec_b = cur_rec;
        if (i_fire) begin
            unique case (i_item.action)
                ACT_CLEAR: begin
                    n_seen     = 1'b0;
                    n_pending  = 32'd0;
                    n_loop_pc  = 16'd0;
                    n_loop_len = 3'd1;
                    n_loop_op  = '0;
                end
                ACT_FLUSH: begin
                    if (i_cfg.rec_en && r_pending != 32'd0) begin
                        o_emit.n_rec      = 2'd1;
                        o_emit.rec_a.last = 1'b1;
                        n_pending         = 32'd0;
                    end
                end
                ACT_INSTR: begin
                    if (i_cfg.rec_en && in_win) begin
                        if (r_seen && i_item.next_pc == i_item.instr_pc) begin
                            // self-loop: fold time into the pending count
                            if (r_pending == 32'd0) begin
                                n_loop_pc  = i_item.instr_pc;
                                n_loop_len = len_c;
                                n_loop_op  = op_pad;
                            end
                            n_pending = part2;
                        end else begin
                            n_seen = 1'b1;
                            if (r_pending != 32'd0) begin
                                o_emit.n_rec = 2'd2;
                                n_pending    = 32'd0;
                            end else begin
                                o_emit.n_rec = 2'd1;
                                o_emit.rec_a = cur_rec;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= 1'b0;
            r_pending  <= 32'd0;
            r_loop_pc  <= 16'd0;
            r_loop_len <= 3'd1;
            r_loop_op  <= '0;
        end else begin
            r_seen     <= n_seen;
            r_pending  <= n_pending;
            r_loop_pc  <= n_loop_pc;
            r_loop_len <= n_loop_len;
            r_loop_op  <= n_loop_op;
        end
    end

    a_two_rec_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit.n_rec == 2'd2) |-> (!o_emit.rec_a.last && o_emit.rec_b.last))
        else $error("collapsed record must precede the final record");

    a_one_rec_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit.n_rec == 2'd1) |-> o_emit.rec_a.last)
        else $error("single record must be marked last");

    a_emit_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit.n_rec != 2'd0) |=> (r_pending == 32'd0 && r_seen == $past(n_seen)))
        else $error("pending count not cleared after emission");

endmodule

>>> hdl/itlc_rec_fifo.sv
// itlc_rec_fifo: four-entry record queue taking up to two records per cycle
// depends on itlc_pkg
module itlc_rec_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  itlc_pkg::t_emit   i_emit,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output itlc_pkg::t_record o_rec
);
    import itlc_pkg::*;

    t_record     r_mem [4];
    logic [1:0]  r_wr_ptr;
    logic [1:0]  r_rd_ptr;
    logic [2:0]  r_count;
    logic [1:0]  n_wr_ptr;
    logic [1:0]  n_rd_ptr;
    logic [2:0]  n_count;
    logic        pop;

    assign o_valid = (r_count != 3'd0);
    assign o_room  = (r_count <= 3'd2);
    assign o_rec   = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr + i_emit.n_rec;
        n_rd_ptr = r_rd_ptr + {1'b0, pop};
        n_count  = r_count + {1'b0, i_emit.n_rec} - {2'd0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.n_rec != 2'd0) begin
            r_mem[r_wr_ptr] <= i_emit.rec_a;
        end
        if (i_emit.n_rec == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= i_emit.rec_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("record queue count out of range");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_emit.n_rec != 2'd0) |-> o_room)
        else $error("records pushed without room");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != 3'd4) |-> (r_wr_ptr == r_rd_ptr + r_count[1:0]))
        else $error("queue pointers disagree with count");

endmodule

>>> hdl/instruction_trace_loop_collapser_top.sv
// instruction_trace_loop_collapser_top: stream ports, config registers, input register
// depends on itlc_pkg, itlc_core and itlc_rec_fifo
// path: an accepted request waits in the input register; its records then pass the record queue
// throughput: one request per cycle while the queue has room; a request can yield two records
// the record queue (4 entries) sets input back-pressure when fewer than two entries are free
// reset: synchronous active low; window 0..0xFFFF, recording closed, collapse state cleared
module instruction_trace_loop_collapser_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // instr_pc, next_pc, total_cycles, wait_cycles, instr_length, opcode_in0..3
    input  logic [itlc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // action
    input  logic [itlc_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // record_pc, record_length, opcode_out0..3, wait_count
    output logic [itlc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [1:0]                       i_cfg_index,
    input  logic [15:0]                      i_cfg_data
);
    import itlc_pkg::*;

    t_cfg     r_cfg;
    logic     r_in_valid;
    t_item    r_item;
    t_item    in_item;
    logic     core_fire;
    logic     fifo_room;
    t_emit    emit;
    t_record  out_rec;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_lo <= 16'd0;
            r_cfg.win_hi <= PC_MAX;
            r_cfg.rec_en <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_WIN_LO: r_cfg.win_lo <= i_cfg_data;
                CFG_WIN_HI: r_cfg.win_hi <= i_cfg_data;
                CFG_REC_EN: r_cfg.rec_en <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        in_item.action    = s_axis_tuser;
        in_item.instr_pc  = s_axis_tdata[15:0];
        in_item.next_pc   = s_axis_tdata[31:16];
        in_item.total_cyc = s_axis_tdata[63:32];
        in_item.wait_cyc  = s_axis_tdata[95:64];
        in_item.len       = s_axis_tdata[98:96];
        in_item.op        = s_axis_tdata[130:99];
    end

    assign core_fire     = r_in_valid && fifo_room;
    assign s_axis_tready = !r_in_valid || core_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item <= in_item;
        end
    end

    itlc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (core_fire),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_emit  (emit)
    );

    itlc_rec_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .o_room  (fifo_room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rec   (out_rec)
    );

    assign m_axis_tdata = {5'd0, out_rec.wait_cyc, out_rec.op, out_rec.len, out_rec.pc};
    assign m_axis_tlast = out_rec.last;

    a_stall_holds_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fifo_room) |=> (r_in_valid && $stable(r_item)))
        else $error("held request lost while queue full");

    a_fire_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit.n_rec != 2'd0) |-> core_fire)
        else $error("records emitted without a request");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input stalled with empty input register");

endmodule
